/* rtl/core/four_level_page_table_manager_assert.svh */
// Assertion macros for the page-table manager.
// Used by the top level; no other dependencies.
`ifndef FOUR_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define FLPT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("flpt check failed");
`define FLPT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("flpt check failed");
`else
`define FLPT_ASSERT_IMP(label, clk, rst_n, a, c)
`define FLPT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/core/flpt_pkg.sv */
// Package for the page-table manager: sizes, ops, entry bits.
// No dependencies.
package flpt_pkg;
    localparam int TableFrames = 16;
    localparam int FrameW = $clog2(TableFrames);
    localparam int CntW = $clog2(TableFrames + 1);
    localparam int MemDepth = TableFrames * 512;
    localparam int MemAw = $clog2(MemDepth);

    localparam logic [2:0] OP_TRANSLATE = 3'd0;
    localparam logic [2:0] OP_MAP = 3'd1;
    localparam logic [2:0] OP_UNMAP = 3'd2;
    localparam logic [2:0] OP_GET = 3'd3;
    localparam logic [2:0] OP_SET = 3'd4;

    localparam logic [63:0] ADDR_MASK = 64'h000f_ffff_ffff_f000;
    localparam logic [63:0] HUGE_MASK = 64'h000f_ffff_ffe0_0000;
    localparam logic [0:0] REG_BASE = 1'b0;
    localparam logic [0:0] REG_VALID = 1'b1;

    function automatic logic [63:0] leaf_bits(input logic [3:0] fl);
        logic [63:0] v;
        v = 64'd1;
        v[1] = fl[1];
        v[2] = fl[2];
        v[63] = ~fl[3];
        return v;
    endfunction
endpackage

/* rtl/core/flpt_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module flpt_ram #(
    parameter int Width = 64,
    parameter int Depth = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/core/four_level_page_table_manager.sv */
// Four-level page-table manager: walks, maps and edits tables in one RAM.
// Each table that map allocates adds a sweep that zeroes its 512 entries, then a link step.
// Throughput: one request at a time; the next can be accepted in the cycle m_tvalid rises.
// After reset the RAM is swept to zero; no request is accepted during the sweep.
// Depends on flpt_pkg and flpt_ram; includes the assertion header.
`include "four_level_page_table_manager_assert.svh"
module four_level_page_table_manager (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], va[66:3], pa[118:67], page_flags[122:119], zero pad
    input  logic [127:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], phys_out[52:1], flags_out[56:53], zero pad
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_RD    = 11'b00000000100,
        ST_DEC   = 11'b00000001000,
        ST_ZERO  = 11'b00000010000,
        ST_LINK  = 11'b00000100000,
        ST_LEAFR = 11'b00001000000,
        ST_LEAFD = 11'b00010000000,
        ST_RBACK = 11'b00100000000,
        ST_DONE  = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [51:0] base_reg;
    logic        valid_reg;
    logic [2:0]  op_reg;
    logic [63:0] va_reg;
    logic [51:0] pa_reg;
    logic [3:0]  fl_reg;
    logic [1:0]  lv_reg, lv_next;
    logic [flpt_pkg::FrameW-1:0] fr_reg, fr_next;
    logic [flpt_pkg::CntW-1:0] used_reg, used_next, saved_reg, saved_next;
    logic [flpt_pkg::MemAw-1:0] clr_reg, clr_next;
    logic [flpt_pkg::MemAw-1:0] slot_reg [3];
    logic [1:0]  nalloc_reg, nalloc_next;
    logic [flpt_pkg::MemAw-1:0] cur_slot_reg, cur_slot_next;
    logic        ok_reg, ok_next;
    logic [51:0] pout_reg, pout_next;
    logic [3:0]  fout_reg, fout_next;
    logic        mv_reg, mv_next;
    logic [63:0] mdata_reg;

    logic        we;
    logic [flpt_pkg::MemAw-1:0] addr;
    logic [63:0] wdata, rdata;

    flpt_ram #(.Width(64), .Depth(flpt_pkg::MemDepth)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [51:0] off;
    logic [8:0]  idx;
    logic        in_store, canon, acc;
    logic [flpt_pkg::FrameW-1:0] ef;

    assign pready = 1'b1;
    assign prdata = paddr[3] ? {63'd0, valid_reg} : {12'd0, base_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign acc = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata = mdata_reg;

    always_comb
    begin
        unique case (lv_reg)
            2'd0: idx = va_reg[47:39];
            2'd1: idx = va_reg[38:30];
            2'd2: idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end
    assign canon = (va_reg[63:48] == 16'h0000) || (va_reg[63:48] == 16'hffff);
    assign off = {rdata[51:12], 12'd0} - {base_reg[51:12], 12'd0};
    assign in_store = (off[51:12] < 40'(flpt_pkg::TableFrames));
    assign ef = off[12 +: flpt_pkg::FrameW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 52'd4096;
            valid_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3] == flpt_pkg::REG_VALID)
            begin
                valid_reg <= pwdata[0];
            end
            else
            begin
                base_reg <= pwdata[51:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op_reg <= s_tdata[2:0];
            va_reg <= s_tdata[66:3];
            pa_reg <= s_tdata[118:67];
            fl_reg <= s_tdata[122:119];
        end
        if (state_reg == ST_LINK)
        begin
            slot_reg[nalloc_reg] <= cur_slot_reg;
        end
        if (state_reg == ST_OUT && !mv_reg)
        begin
            mdata_reg <= {7'd0, fout_reg, pout_reg, ok_reg};
        end
    end

    logic [63:0] new_tab;
    assign new_tab = {12'd0, (({base_reg[51:12], 12'd0} + {35'd0, used_reg, 12'd0})
                   & flpt_pkg::ADDR_MASK[51:0])
                   | 52'd3 | {49'd0, fl_reg[2], 2'd0}};

    always_comb
    begin
        state_next = state_reg;
        lv_next = lv_reg;
        fr_next = fr_reg;
        used_next = used_reg;
        saved_next = saved_reg;
        clr_next = clr_reg;
        nalloc_next = nalloc_reg;
        cur_slot_next = cur_slot_reg;
        ok_next = ok_reg;
        pout_next = pout_reg;
        fout_next = fout_reg;
        mv_next = mv_reg && !m_tready;
        we = 1'b0;
        addr = {fr_reg, idx};
        wdata = 64'd0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    lv_next = 2'd0;
                    fr_next = '0;
                    nalloc_next = 2'd0;
                    saved_next = used_reg;
                    ok_next = 1'b0;
                    pout_next = '0;
                    fout_next = '0;
                    state_next = ST_DONE;
                    priority if (!valid_reg) state_next = ST_DONE;
                    else if (s_tdata[2:0] == flpt_pkg::OP_MAP)
                    begin
                        // user pages only below the upper half
                        if (s_tdata[119] && (s_tdata[118:79] != 40'd0)
                            && !(s_tdata[121] && (s_tdata[50] || (s_tdata[66:51] != 16'h0)))
                            && ((s_tdata[66:51] == 16'h0)
                                || (s_tdata[66:51] == 16'hffff)))
                            state_next = ST_RD;
                    end
                    else if (s_tdata[2:0] <= flpt_pkg::OP_SET) state_next = ST_RD;
                    else state_next = ST_DONE;
                end
            end
            ST_RD:
            begin
                cur_slot_next = {fr_reg, idx};
                if ((op_reg == flpt_pkg::OP_TRANSLATE || op_reg == flpt_pkg::OP_UNMAP)
                    && !canon)
                    state_next = ST_DONE;
                else
                    state_next = (lv_reg == 2'd3) ? ST_LEAFD : ST_DEC;
            end
            ST_DEC:
            begin
                state_next = ST_RD;
                lv_next = lv_reg + 1'b1;
                fr_next = ef;
                priority if (!rdata[0])
                begin
                    if (op_reg == flpt_pkg::OP_MAP)
                    begin
                        // hold the level; the link step advances it
                        lv_next = lv_reg;
                        if (used_reg >= flpt_pkg::CntW'(flpt_pkg::TableFrames))
                            state_next = ST_RBACK;
                        else
                        begin
                            clr_next = {used_reg[flpt_pkg::FrameW-1:0], 9'd0};
                            state_next = ST_ZERO;
                        end
                    end
                    else state_next = ST_DONE;
                end
                else if (op_reg == flpt_pkg::OP_TRANSLATE && lv_reg == 2'd2 && rdata[7])
                begin
                    ok_next = 1'b1;
                    pout_next = rdata[51:0] & flpt_pkg::HUGE_MASK[51:0]
                              | {31'd0, va_reg[20:0]};
                    state_next = ST_DONE;
                end
                else if (rdata[7] && op_reg != flpt_pkg::OP_TRANSLATE)
                    state_next = (op_reg == flpt_pkg::OP_MAP) ? ST_RBACK : ST_DONE;
                else if (!in_store)
                    state_next = (op_reg == flpt_pkg::OP_MAP) ? ST_RBACK : ST_DONE;
                else state_next = ST_RD;
            end
            ST_ZERO:
            begin
                we = 1'b1;
                addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg[8:0]) state_next = ST_LINK;
            end
            ST_LINK:
            begin
                we = 1'b1;
                addr = cur_slot_reg;
                wdata = new_tab;
                used_next = used_reg + 1'b1;
                nalloc_next = nalloc_reg + 1'b1;
                lv_next = lv_reg + 1'b1;
                fr_next = used_reg[flpt_pkg::FrameW-1:0];
                state_next = ST_RD;
                // A new table's address must still resolve into the store.
                if (((new_tab[51:0] - {base_reg[51:12], 12'd0}) >> 12)
                    >= 52'(flpt_pkg::TableFrames))
                    state_next = ST_RBACK;
            end
            ST_LEAFD:
            begin
                state_next = ST_DONE;
                unique case (op_reg)
                    flpt_pkg::OP_TRANSLATE:
                    begin
                        if (rdata[0])
                        begin
                            ok_next = 1'b1;
                            pout_next = {rdata[51:12], va_reg[11:0]};
                        end
                    end
                    flpt_pkg::OP_MAP:
                    begin
                        if (rdata[0]) state_next = ST_RBACK;
                        else
                        begin
                            we = 1'b1;
                            addr = cur_slot_reg;
                            wdata = {12'd0, pa_reg[51:12], 12'd0}
                                  | flpt_pkg::leaf_bits(fl_reg);
                            ok_next = 1'b1;
                        end
                    end
                    flpt_pkg::OP_UNMAP:
                    begin
                        we = 1'b1;
                        addr = cur_slot_reg;
                        ok_next = 1'b1;
                    end
                    flpt_pkg::OP_GET:
                    begin
                        if (rdata[0])
                        begin
                            ok_next = 1'b1;
                            fout_next = {~rdata[63], rdata[2], rdata[1], 1'b1};
                        end
                    end
                    default:
                    begin
                        if (rdata[0])
                        begin
                            we = 1'b1;
                            addr = cur_slot_reg;
                            wdata = (rdata & flpt_pkg::ADDR_MASK)
                                  | flpt_pkg::leaf_bits(fl_reg);
                            ok_next = 1'b1;
                        end
                    end
                endcase
            end
            ST_RBACK:
            begin
                // Unlink allocated tables, newest first.
                if (nalloc_reg == 2'd0)
                begin
                    used_next = saved_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    we = 1'b1;
                    addr = slot_reg[nalloc_reg - 1'b1];
                    nalloc_next = nalloc_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_OUT;
            end
            default:
            begin
                if (!mv_reg)
                begin
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            lv_reg <= '0;
            fr_reg <= '0;
            used_reg <= flpt_pkg::CntW'(1);
            saved_reg <= flpt_pkg::CntW'(1);
            clr_reg <= '0;
            nalloc_reg <= '0;
            cur_slot_reg <= '0;
            ok_reg <= 1'b0;
            pout_reg <= '0;
            fout_reg <= '0;
            mv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lv_reg <= lv_next;
            fr_reg <= fr_next;
            used_reg <= used_next;
            saved_reg <= saved_next;
            clr_reg <= clr_next;
            nalloc_reg <= nalloc_next;
            cur_slot_reg <= cur_slot_next;
            ok_reg <= ok_next;
            pout_reg <= pout_next;
            fout_reg <= fout_next;
            mv_reg <= mv_next;
        end
    end

    `FLPT_ASSERT_IMP(a_no_acc_busy, clk, rst_n, state_reg != ST_IDLE, !s_tready)
    `FLPT_ASSERT_IMP(a_used_max, clk, rst_n, 1'b1,
        used_reg <= flpt_pkg::CntW'(flpt_pkg::TableFrames))
    `FLPT_ASSERT_NXT(a_fail_clean, clk, rst_n, state_reg == ST_DONE && !ok_reg,
        pout_reg == 52'd0)
endmodule

/* tb/sv/tb.sv */
// Testbench for four_level_page_table_manager: stream requests in, results checked.
// Holds its own model of the page-table store. Depends on flpt_pkg and the RTL.
module tb;
    typedef struct packed {
        logic [3:0]  flags;
        logic [51:0] pa;
        logic [63:0] va;
        logic [2:0]  op;
    } pt_req_t;

    typedef struct packed {
        logic [3:0]  flags;
        logic [51:0] phys;
        logic        ok;
    } pt_res_t;

    localparam logic [51:0] MASK_A = 52'hf_ffff_ffff_f000;
    localparam logic [51:0] MASK_H = 52'hf_ffff_ffe0_0000;
    localparam logic [63:0] USER_TOP = 64'h0000_8000_0000_0000;
    localparam logic [3:0] ADDR_BASE = {flpt_pkg::REG_BASE, 3'd0};
    localparam logic [3:0] ADDR_VALID = {flpt_pkg::REG_VALID, 3'd0};

    logic clk;
    logic rst_n;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [127:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    four_level_page_table_manager dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // model state
    logic [63:0] pt_mem [flpt_pkg::MemDepth];
    int unsigned frames_used;
    logic [51:0] base_reg;
    logic        space_ok;

    pt_req_t req_q[$];
    pt_res_t result_q[$];
    pt_req_t cur_req;
    int errors = 0;
    bit calm = 0;
    bit hold_req = 0;
    int hold_cnt = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit canon(input logic [63:0] va);
        return va[63:48] == 16'h0 || va[63:48] == 16'hffff;
    endfunction

    function automatic int idx(input logic [63:0] va, input int lv);
        return int'((va >> (39 - 9 * lv)) & 64'h1ff);
    endfunction

    function automatic bit frame_from(input logic [63:0] e, output int fr);
        logic [51:0] off;
        off = (e[51:0] & MASK_A) - (base_reg & MASK_A);
        fr = int'(off >> 12);
        return (off >> 12) < flpt_pkg::TableFrames;
    endfunction

    function automatic logic [63:0] leaf_entry(input logic [3:0] fl);
        logic [63:0] v;
        v = 64'd1;
        v[1] = fl[1];
        v[2] = fl[2];
        v[63] = ~fl[3];
        return v;
    endfunction

    function automatic bit find_leaf(input logic [63:0] va, output int slot);
        int fr;
        logic [63:0] e;
        fr = 0;
        slot = 0;
        for (int lv = 0; lv < 3; lv++)
        begin
            e = pt_mem[fr * 512 + idx(va, lv)];
            if (!e[0] || e[7]) return 0;
            if (!frame_from(e, fr)) return 0;
        end
        slot = fr * 512 + idx(va, 3);
        return 1;
    endfunction

    function automatic bit model_map(input logic [63:0] va_in, input logic [51:0] pa_in,
                                     input logic [3:0] fl);
        int slots[3];
        int nalloc;
        int saved;
        int fr;
        int s;
        int nf;
        logic [63:0] va;
        logic [63:0] e;
        bit fail;
        nalloc = 0;
        saved = frames_used;
        fr = 0;
        fail = 0;
        va = va_in & ~64'hfff;
        if (!fl[0] || !canon(va)) return 0;
        if (fl[2] && va >= USER_TOP) return 0;
        if ((pa_in & MASK_A) == 0) return 0;
        for (int lv = 0; lv < 3 && !fail; lv++)
        begin
            s = fr * 512 + idx(va, lv);
            e = pt_mem[s];
            if (!e[0])
            begin
                if (frames_used >= flpt_pkg::TableFrames)
                begin
                    fail = 1;
                    break;
                end
                nf = frames_used;
                frames_used++;
                for (int k = 0; k < 512; k++) pt_mem[nf * 512 + k] = '0;
                e = '0;
                e[51:0] = ((base_reg & MASK_A) + (52'(nf) << 12)) & MASK_A;
                e[0] = 1'b1;
                e[1] = 1'b1;
                e[2] = fl[2];
                pt_mem[s] = e;
                slots[nalloc] = s;
                nalloc++;
            end
            if (e[7] || !frame_from(e, fr)) fail = 1;
        end
        if (!fail)
        begin
            s = fr * 512 + idx(va, 3);
            if (pt_mem[s][0]) fail = 1;
            else pt_mem[s] = {12'b0, pa_in & MASK_A} | leaf_entry(fl);
        end
        if (fail)
        begin
            // undo tables linked by this request
            for (int i = 0; i < nalloc; i++) pt_mem[slots[i]] = '0;
            frames_used = saved;
            return 0;
        end
        return 1;
    endfunction

    function automatic pt_res_t apply_request(input pt_req_t r);
        pt_res_t res;
        int fr;
        int slot;
        logic [63:0] e;
        logic [63:0] va;
        res = '0;
        if (!space_ok) return res;
        case (r.op)
            flpt_pkg::OP_TRANSLATE:
            begin
                if (canon(r.va))
                begin
                    fr = 0;
                    for (int lv = 0; lv < 4; lv++)
                    begin
                        e = pt_mem[fr * 512 + idx(r.va, lv)];
                        if (!e[0]) break;
                        if (lv == 2 && e[7])
                        begin
                            res.ok = 1;
                            res.phys = (e[51:0] & MASK_H) | {31'd0, r.va[20:0]};
                            break;
                        end
                        if (lv == 3)
                        begin
                            res.ok = 1;
                            res.phys = (e[51:0] & MASK_A) | {40'd0, r.va[11:0]};
                            break;
                        end
                        if (!frame_from(e, fr)) break;
                    end
                end
            end
            flpt_pkg::OP_MAP: res.ok = model_map(r.va, r.pa, r.flags);
            flpt_pkg::OP_UNMAP:
            begin
                va = r.va & ~64'hfff;
                if (canon(va) && find_leaf(va, slot))
                begin
                    pt_mem[slot] = '0;
                    res.ok = 1;
                end
            end
            flpt_pkg::OP_GET:
            begin
                if (find_leaf(r.va, slot) && pt_mem[slot][0])
                begin
                    e = pt_mem[slot];
                    res.flags = {~e[63], e[2], e[1], 1'b1};
                    res.ok = 1;
                end
            end
            flpt_pkg::OP_SET:
            begin
                if (find_leaf(r.va, slot) && pt_mem[slot][0])
                begin
                    pt_mem[slot] = (pt_mem[slot] & 64'(MASK_A)) | leaf_entry(r.flags);
                    res.ok = 1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready) result_q.push_back(apply_request(cur_req));
            if (!s_tvalid || s_tready)
            begin
                if (req_q.size() > 0 && (calm || $urandom_range(99) >= 30))
                begin
                    cur_req = req_q.pop_front();
                    s_tdata <= {5'b0, cur_req};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && hold_cnt == 0)
        begin
            hold_cnt = 400;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= calm || $urandom_range(99) >= 30;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pt_res_t got;
        pt_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[56:0];
            if (result_q.size() == 0)
            begin
                report("unexpected result", m_tdata, '0);
            end
            else
            begin
                want = result_q.pop_front();
                if (got.ok !== want.ok) report("ok", got.ok, want.ok);
                if (got.phys !== want.phys) report("phys_out", got.phys, want.phys);
                if (got.flags !== want.flags) report("flags_out", got.flags, want.flags);
            end
        end
    end

    task automatic reg_write(input logic [3:0] addr, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[3] == flpt_pkg::REG_BASE) base_reg = value[51:0];
        else space_ok = value[0];
    endtask

    task automatic drain();
        wait (req_q.size() == 0 && !s_tvalid && result_q.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    function automatic pt_req_t req(input logic [2:0] op, input logic [63:0] va,
                                    input logic [51:0] pa, input logic [3:0] fl);
        pt_req_t r;
        r.op = op;
        r.va = va;
        r.pa = pa;
        r.flags = fl;
        return r;
    endfunction

    function automatic pt_req_t rand_req();
        pt_req_t r;
        int pick;
        int ids[4] = '{0, 1, 2, 511};
        logic [63:0] va;
        pick = $urandom_range(99);
        if (pick < 30) r.op = flpt_pkg::OP_MAP;
        else if (pick < 55) r.op = flpt_pkg::OP_TRANSLATE;
        else if (pick < 65) r.op = flpt_pkg::OP_UNMAP;
        else if (pick < 80) r.op = flpt_pkg::OP_GET;
        else if (pick < 95) r.op = flpt_pkg::OP_SET;
        else r.op = 3'($urandom_range(7, 5));
        va = {$urandom, $urandom};
        if ($urandom_range(9) != 0)
        begin
            // narrow index pool so walks hit existing tables
            va[47:39] = 9'(ids[$urandom_range(3)]);
            va[38:30] = 9'(ids[$urandom_range(3)]);
            va[29:21] = 9'(ids[$urandom_range(3)]);
            va[20:12] = 9'(ids[$urandom_range(3)]);
            va[63:48] = {16{va[47]}};
            if ($urandom_range(19) == 0) va[63:48] = 16'($urandom);
        end
        r.va = va;
        r.pa = 52'({$urandom, $urandom});
        if ($urandom_range(19) == 0) r.pa[51:12] = '0;
        r.flags = 4'($urandom);
        if (r.op == flpt_pkg::OP_MAP && $urandom_range(99) < 85) r.flags[0] = 1'b1;
        return r;
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) req_q.push_back(rand_req());
    endtask

    initial begin
        logic [63:0] va_a;
        logic [63:0] va_hi;
        for (int i = 0; i < flpt_pkg::MemDepth; i++) pt_mem[i] = '0;
        frames_used = 1;
        base_reg = 52'd4096;
        space_ok = 1'b1;
        va_a = 64'h0000_0040_2030_1abc;
        va_hi = 64'hffff_8000_0000_0123;
        wait (rst_n);
        reg_write(ADDR_BASE, 64'd4096);
        reg_write(ADDR_VALID, 64'd1);

        req_q.push_back(req(flpt_pkg::OP_MAP, va_a, 52'h1_2345_6000, 4'b0011));
        req_q.push_back(req(flpt_pkg::OP_TRANSLATE, va_a, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_GET, va_a, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_SET, va_a, '0, 4'b1110));
        req_q.push_back(req(flpt_pkg::OP_GET, va_a, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_MAP, va_a, 52'h2000, 4'b0001));
        req_q.push_back(req(flpt_pkg::OP_UNMAP, va_a, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_TRANSLATE, va_a, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_UNMAP, va_a, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_MAP, va_hi, 52'h3000, 4'b0101));
        req_q.push_back(req(flpt_pkg::OP_MAP, va_hi, 52'hf_ffff_ffff_ffff, 4'b1011));
        req_q.push_back(req(flpt_pkg::OP_TRANSLATE, va_hi, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_MAP, 64'hffff_0000_0000_1000, 52'h7000, 4'b0101));
        req_q.push_back(req(flpt_pkg::OP_MAP, 64'h1000, 52'h5000, 4'b0110));
        req_q.push_back(req(flpt_pkg::OP_MAP, 64'h1000, 52'h0fff, 4'b0111));
        req_q.push_back(req(flpt_pkg::OP_MAP, 64'h1000, 52'h5000, 4'b1111));
        req_q.push_back(req(flpt_pkg::OP_TRANSLATE, 64'h0001_0000_0000_1000, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_MAP, 64'h0001_0000_0000_1000, 52'h5000, 4'b0001));
        req_q.push_back(req(flpt_pkg::OP_GET, 64'h0001_0000_0000_1000, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_TRANSLATE, 64'hffff_ffff_ffff_ffff, '0, '0));
        req_q.push_back(req(3'd5, va_a, '1, 4'hf));
        req_q.push_back(req(3'd6, '1, '1, 4'hf));
        req_q.push_back(req(3'd7, '0, '0, '0));
        req_q.push_back(req(flpt_pkg::OP_SET, 64'h1000, '0, 4'b0000));
        req_q.push_back(req(flpt_pkg::OP_GET, 64'h1000, '0, '0));
        run_random(150);
        drain();

        // fast stretch, then a long hold-off on the result side
        calm = 1;
        run_random(80);
        wait (req_q.size() < 70);
        hold_req = 1;
        drain();
        calm = 0;

        reg_write(ADDR_VALID, 64'd0);
        run_random(25);
        drain();
        reg_write(ADDR_VALID, 64'd1);
        reg_write(ADDR_BASE, 64'd0);
        run_random(80);
        drain();
        reg_write(ADDR_BASE, 64'h000f_ffff_ffff_f000);
        run_random(80);
        drain();
        reg_write(ADDR_BASE, 64'hfff0_1234_5678_9abc);
        run_random(30);
        drain();
        reg_write(ADDR_BASE, 64'd4096);
        run_random(60);
        drain();

        if (errors == 0 && result_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
